// ----- rtl/kti_pkg.sv -----
// Package for the keyframe track interpolator: command codes and shared types.
// Depends on nothing; used by every module of the block.
package kti_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam int SPAN_BITS = 16;
    localparam int TIME_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic                  start;
        logic [TIME_BITS+FRAC_BITS-1:0] dividend;
        logic [TIME_BITS+FRAC_BITS-1:0] divisor;
    } div_req_t;

    // Status from the divider back to the sequencer.
    typedef struct packed {
        logic                  done;
        logic [TIME_BITS+FRAC_BITS-1:0] quotient;
        logic [TIME_BITS+FRAC_BITS-1:0] remainder;
    } div_rsp_t;

endpackage

// ----- rtl/keyframe_track_interpolator_unit.sv -----
// Top level of the keyframe track interpolator: keyframe memories and sequencer.
// Depends on kti_pkg, kti_divider and kti_blend.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  command .. wrap_mode
//   out       output     out_valid / out_stall result_valid .. lerp_w
//   cfg       input      cfg_we               cfg_data (frames_in_use)
//
// A write command is registered and then written to both memories. An evaluate
// for N frames in use does one memory read per frame to sum the spans, up to one
// per frame to find the span, then the modulo (wrap mode only) and the fraction
// in the shared bit-serial divider, then two memory reads and the blend.
// Reset clears the control state and frames_in_use; the memories hold no reset.
// A waiting result does not block a new item from being accepted; the next
// result only waits for out_stall to fall.
module keyframe_track_interpolator_unit
    import kti_pkg::*;
#(
    parameter int MAX_KEYS       = 16,
    parameter int COMPONENT_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [4:0]                       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [3:0]                       frame_slot,
    input  logic [15:0]                      frame_ticks,
    input  logic signed [COMPONENT_BITS-1:0] value_x,
    input  logic signed [COMPONENT_BITS-1:0] value_y,
    input  logic signed [COMPONENT_BITS-1:0] value_z,
    input  logic signed [COMPONENT_BITS-1:0] value_w,
    input  logic [31:0]                      query_time,
    input  logic                             wrap_mode,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             result_valid,
    output logic [3:0]                       segment,
    output logic signed [COMPONENT_BITS-1:0] lerp_x,
    output logic signed [COMPONENT_BITS-1:0] lerp_y,
    output logic signed [COMPONENT_BITS-1:0] lerp_z,
    output logic signed [COMPONENT_BITS-1:0] lerp_w
);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int KW = 4 * COMPONENT_BITS;
    localparam int DW = TIME_BITS + FRAC_BITS;
    localparam int TW = SPAN_BITS + CW;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_TIME, S_MOD, S_SCAN, S_FRAC, S_RD_L, S_RD_R,
        S_BLEND, S_DONE, S_OUT
    } state_t;

    // Span and key memories with a registered read.
    logic [SPAN_BITS-1:0] span_mem [MAX_KEYS];
    logic [KW-1:0]        key_mem  [MAX_KEYS];
    logic [SPAN_BITS-1:0] span_rd_reg;
    logic [KW-1:0]        key_rd_reg;
    logic [AW-1:0]        rd_addr;

    state_t         state_reg;
    logic [4:0]     fiu_reg;
    logic [CW-1:0]  n_reg, idx_reg;
    logic           rd_pend_reg;
    logic [TW-1:0]  total_reg, start_reg;
    logic [31:0]    tm_reg;
    logic           wrap_reg;
    logic [AW-1:0]  hit_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [KW-1:0]  left_reg;
    logic [1:0]     wait_reg;
    logic           wr_pend_reg;
    logic [AW-1:0]  wr_addr_reg;
    logic [SPAN_BITS-1:0] wr_span_reg;
    logic [KW-1:0]  wr_key_reg;

    logic           out_valid_reg, res_valid_reg;
    logic [KW-1:0]  lerp_reg;
    logic [KW-1:0]  blend_out;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic           accept;
    logic [TW-1:0]  span_end;

    assign in_stall = (state_reg != S_IDLE) || wr_pend_reg;
    assign accept   = in_valid && !in_stall;
    assign span_end = start_reg + TW'(span_rd_reg);

    // Address for every read the sequencer issues.
    always_comb
    begin
        unique case (state_reg)
            S_RD_L:  rd_addr = hit_reg;
            S_RD_R:  rd_addr = (CW'(hit_reg) + 1'b1 >= n_reg) ? '0 : AW'(CW'(hit_reg) + 1'b1);
            default: rd_addr = idx_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            span_mem[wr_addr_reg] <= wr_span_reg;
            key_mem[wr_addr_reg]  <= wr_key_reg;
        end
        span_rd_reg <= span_mem[rd_addr];
        key_rd_reg  <= key_mem[rd_addr];
    end

    kti_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    for (genvar c = 0; c < 4; c++)
    begin : g_lane
        kti_blend #(.COMPONENT_BITS(COMPONENT_BITS)) u_blend (
            .clk     (clk),
            .left    (left_reg[c*COMPONENT_BITS +: COMPONENT_BITS]),
            .right   (key_rd_reg[c*COMPONENT_BITS +: COMPONENT_BITS]),
            .frac    (frac_reg),
            .blended (blend_out[c*COMPONENT_BITS +: COMPONENT_BITS])
        );
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DW'(tm_reg);
        div_req.divisor  = DW'(total_reg);
        if (state_reg == S_TIME && wrap_reg)
            div_req.start = 1'b1;
        if (state_reg == S_SCAN && rd_pend_reg && tm_reg < 32'(span_end)
            && tm_reg >= 32'(start_reg))
        begin
            div_req.start    = 1'b1;
            div_req.dividend = DW'(tm_reg - 32'(start_reg)) << FRAC_BITS;
            div_req.divisor  = DW'(span_rd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fiu_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fiu_reg <= cfg_data;
            // In S_OUT the handshake below decides the flag on its own.
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    // Slots at or above the depth are dropped.
                    wr_pend_reg <= accept && command == CMD_WRITE
                                   && (32'(frame_slot) < 32'(MAX_KEYS));
                    if (accept && command == CMD_WRITE)
                    begin
                        wr_addr_reg <= AW'(frame_slot);
                        wr_span_reg <= frame_ticks;
                        wr_key_reg  <= {value_w, value_x, value_y, value_z} == '0 ? '0 :
                                       {value_w, value_z, value_y, value_x};
                    end
                    else if (accept)
                    begin
                        n_reg       <= (32'(fiu_reg) > 32'(MAX_KEYS)) ? CW'(MAX_KEYS)
                                                                     : CW'(fiu_reg);
                        tm_reg      <= query_time;
                        wrap_reg    <= wrap_mode;
                        idx_reg     <= '0;
                        total_reg   <= '0;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    rd_pend_reg <= (idx_reg < n_reg);
                    if (rd_pend_reg)
                        total_reg <= total_reg + TW'(span_rd_reg);
                    if (idx_reg < n_reg)
                        idx_reg <= idx_reg + 1'b1;
                    else if (!rd_pend_reg)
                        state_reg <= S_TIME;
                end
                S_TIME:
                begin
                    idx_reg     <= '0;
                    start_reg   <= '0;
                    rd_pend_reg <= 1'b0;
                    if (n_reg == '0 || total_reg == '0)
                    begin
                        res_valid_reg <= 1'b0;
                        state_reg     <= S_DONE;
                    end
                    else if (wrap_reg)
                        state_reg <= S_MOD;
                    else
                    begin
                        if (tm_reg > 32'(total_reg))
                            tm_reg <= 32'(total_reg);
                        state_reg <= S_SCAN;
                    end
                end
                S_MOD:
                begin
                    if (div_rsp.done)
                    begin
                        tm_reg    <= div_rsp.remainder[31:0];
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    rd_pend_reg <= (idx_reg < n_reg);
                    if (idx_reg < n_reg)
                        idx_reg <= idx_reg + 1'b1;
                    if (rd_pend_reg)
                    begin
                        if (div_req.start)
                        begin
                            hit_reg   <= AW'(idx_reg - 1'b1);
                            state_reg <= S_FRAC;
                        end
                        start_reg <= span_end;
                    end
                    if (!rd_pend_reg && idx_reg >= n_reg && idx_reg != '0)
                    begin
                        res_valid_reg <= 1'b0;
                        state_reg     <= S_DONE;
                    end
                end
                S_FRAC:
                begin
                    if (div_rsp.done)
                    begin
                        frac_reg  <= div_rsp.quotient[FRAC_BITS-1:0];
                        state_reg <= S_RD_L;
                    end
                end
                S_RD_L:
                    state_reg <= S_RD_R;
                S_RD_R:
                begin
                    left_reg  <= key_rd_reg;
                    wait_reg  <= '0;
                    state_reg <= S_BLEND;
                end
                S_BLEND:
                begin
                    wait_reg <= wait_reg + 1'b1;
                    if (wait_reg == 2'd1)
                    begin
                        res_valid_reg <= 1'b1;
                        lerp_reg      <= blend_out;
                        state_reg     <= S_OUT;
                    end
                end
                S_DONE:
                begin
                    lerp_reg  <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            result_valid <= res_valid_reg;
            segment      <= res_valid_reg ? 4'(hit_reg) : 4'd0;
            lerp_x       <= lerp_reg[0*COMPONENT_BITS +: COMPONENT_BITS];
            lerp_y       <= lerp_reg[1*COMPONENT_BITS +: COMPONENT_BITS];
            lerp_z       <= lerp_reg[2*COMPONENT_BITS +: COMPONENT_BITS];
            lerp_w       <= lerp_reg[3*COMPONENT_BITS +: COMPONENT_BITS];
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ----- rtl/kti_divider.sv -----
// Restoring divider, one quotient bit per cycle, for modulo and fraction.
// Depends on kti_pkg.
module kti_divider
    import kti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int W = TIME_BITS + FRAC_BITS;

    logic [W-1:0] quot_reg, rem_reg, den_reg;
    logic [$clog2(W+1)-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [W:0] trial;
    logic last_step;

    assign trial     = {rem_reg, quot_reg[W-1]} - {1'b0, den_reg};
    assign last_step = (cnt_reg == ($clog2(W+1))'(W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quot_reg <= req.dividend;
                den_reg  <= req.divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                // The remainder stays below the divisor, so one extra bit suffices.
                if (!trial[W])
                begin
                    rem_reg  <= trial[W-1:0];
                    quot_reg <= {quot_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= {rem_reg[W-2:0], quot_reg[W-1]};
                    quot_reg <= {quot_reg[W-2:0], 1'b0};
                end
                if (last_step)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;
endmodule

// ----- rtl/kti_blend.sv -----
// One component blend stage: (l*(65536-t) + r*t) >> 16, truncated toward zero.
// Depends on kti_pkg.
module kti_blend
    import kti_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
)
(
    input  logic                             clk,
    input  logic signed [COMPONENT_BITS-1:0] left,
    input  logic signed [COMPONENT_BITS-1:0] right,
    input  logic        [FRAC_BITS-1:0]      frac,
    output logic signed [COMPONENT_BITS-1:0] blended
);
    localparam int PW = COMPONENT_BITS + FRAC_BITS + 2;

    logic signed [PW-1:0] pl_reg, pr_reg;
    logic signed [PW:0]   acc;
    logic        [PW:0]   mag;

    always_ff @(posedge clk)
    begin
        pl_reg <= PW'(left)  * PW'($signed({1'b0, (FRAC_BITS+1)'(1) << FRAC_BITS})
                  - $signed({2'b0, frac}));
        pr_reg <= PW'(right) * PW'($signed({1'b0, frac}));
    end

    always_comb
    begin
        acc = (PW+1)'(pl_reg) + (PW+1)'(pr_reg);
        mag = acc[PW] ? (PW+1)'(-acc) : acc;
        mag = mag >> FRAC_BITS;
        blended = acc[PW] ? COMPONENT_BITS'(-mag) : COMPONENT_BITS'(mag);
    end
endmodule
